/* rtl/core/video_bus_address_decoder_assert.svh */
// Assertion macros for the video bus address decoder checker.
// Depends on nothing; the including module supplies clock and reset names.
`ifndef VIDEO_BUS_ADDRESS_DECODER_ASSERT_SVH
`define VIDEO_BUS_ADDRESS_DECODER_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define VBAD_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("vbad assertion failed");

// Implication checked in the next cycle, disabled while reset is held.
`define VBAD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("vbad assertion failed");

`endif

/* rtl/core/vbad_pkg.sv */
// Shared types, sizes and decode helpers for the video bus address decoder.
// Depends on nothing; used by the front, queue, back and top modules and the testbench.
`timescale 1ns / 1ps

package vbad_pkg;

    // Store sizes.
    localparam int PATTERN_TABLE_BYTES  = 4096;
    localparam int NAMETABLE_BANK_BYTES = 1024;
    localparam int PALETTE_BYTES        = 32;

    localparam int ADDR_W   = 14;
    localparam int DATA_W   = 8;
    localparam int PAT_AW   = $clog2(2 * PATTERN_TABLE_BYTES);
    localparam int NT_OFF_W = $clog2(NAMETABLE_BANK_BYTES);
    localparam int NT_AW    = NT_OFF_W + 1;
    localparam int PAL_AW   = $clog2(PALETTE_BYTES);
    localparam int IDX_W    = (PAT_AW > NT_AW) ? PAT_AW : NT_AW;

    // Decode boundaries on the video bus.
    localparam logic [ADDR_W-1:0] NT_BASE     = 14'h2000;
    localparam logic [ADDR_W-1:0] NT_MIRROR   = 14'h3000;
    localparam logic [ADDR_W-1:0] MIRROR_STEP = 14'h1000;
    localparam logic [ADDR_W-1:0] PAL_BASE    = 14'h3F00;

    // Queue between the decode side and the memory side.
    localparam int QUEUE_DEPTH = 2;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        REGION_PATTERN   = 2'd0,
        REGION_NAMETABLE = 2'd1,
        REGION_PALETTE   = 2'd2
    } t_region;

    typedef enum logic {
        REQ_READ  = 1'b0,
        REQ_WRITE = 1'b1
    } t_req_type;

    // One decoded access as it travels from front to back.
    typedef struct packed {
        t_region           region;
        logic              is_write;
        logic [IDX_W-1:0]  index;
        logic [DATA_W-1:0] wdata;
    } t_access;

    // Offset within one pattern table: the 12-bit offset wraps modulo the table size.
    // The table size is at least a quarter of 4 KiB, so two conditional subtracts do.
    function automatic logic [11:0] pat_offset(input logic [11:0] off);
        logic [13:0] r;
        r = {2'b00, off};
        if (r >= 14'(2 * PATTERN_TABLE_BYTES)) begin
            r = r - 14'(2 * PATTERN_TABLE_BYTES);
        end
        if (r >= 14'(PATTERN_TABLE_BYTES)) begin
            r = r - 14'(PATTERN_TABLE_BYTES);
        end
        return r[11:0];
    endfunction

endpackage

/* rtl/core/vbad_front.sv */
// Front side: holds the mirroring mode register and decodes one bus access
// into a store and an entry index. Depends on vbad_pkg.
`timescale 1ns / 1ps

module vbad_front import vbad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_bus_address,
    input  logic [DATA_W-1:0] i_write_byte,
    output t_access           o_access
);

    logic              r_bank_by_high_bit;
    logic [11:0]       pat_off;
    logic [PAT_AW-1:0] pat_idx;
    logic [ADDR_W-1:0] nt_addr;
    logic              nt_bank;

    // Mode register: picks which address bit selects the nametable bank.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bank_by_high_bit <= 1'b0;
        end else if (i_cfg_we) begin
            r_bank_by_high_bit <= i_cfg_wdata;
        end
    end

    // Pattern index: bit 12 picks the table, the wrapped offset the entry.
    always_comb begin
        pat_off = pat_offset(i_bus_address[11:0]);
        if (i_bus_address[12]) begin
            pat_idx = PAT_AW'(PATTERN_TABLE_BYTES) + PAT_AW'(pat_off);
        end else begin
            pat_idx = PAT_AW'(pat_off);
        end
    end

    // Nametable index: the upper range mirrors down onto the lower one.
    always_comb begin
        if (i_bus_address >= NT_MIRROR) begin
            nt_addr = i_bus_address - MIRROR_STEP;
        end else begin
            nt_addr = i_bus_address;
        end
        nt_bank = r_bank_by_high_bit ? nt_addr[11] : nt_addr[10];
    end

    // Region select and packing of the decoded access.
    always_comb begin
        o_access.is_write = (t_req_type'(i_req_type) == REQ_WRITE);
        o_access.wdata    = i_write_byte;
        priority if (i_bus_address < NT_BASE) begin
            o_access.region = REGION_PATTERN;
            o_access.index  = IDX_W'(pat_idx);
        end else if (i_bus_address < PAL_BASE) begin
            o_access.region = REGION_NAMETABLE;
            o_access.index  = IDX_W'({nt_bank, nt_addr[NT_OFF_W-1:0]});
        end else begin
            o_access.region = REGION_PALETTE;
            o_access.index  = IDX_W'(i_bus_address[PAL_AW-1:0]);
        end
    end

endmodule

/* rtl/core/vbad_queue.sv */
// Short queue of decoded accesses between the front and back sides.
// Depends on vbad_pkg.
`timescale 1ns / 1ps

module vbad_queue import vbad_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_access i_access,
    input  logic    i_pop,
    output logic    o_full,
    output logic    o_valid,
    output t_access o_access
);

    t_access              r_slot [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_CNT_W-1:0]   r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full   = (r_count == Q_CNT_W'(QUEUE_DEPTH));
    assign o_valid  = (r_count != '0);
    assign o_access = r_slot[r_rd_ptr];
    assign do_push  = i_push && !o_full;
    assign do_pop   = i_pop && o_valid;

    // Slot storage; payload needs no reset.
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_access;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == Q_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

/* rtl/core/vbad_back.sv */
// Back side: the pattern, nametable and palette memories, one access per
// cycle with registered read data, and the result strobe. Depends on vbad_pkg.
`timescale 1ns / 1ps

module vbad_back import vbad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  t_access           i_access,
    output logic              o_done,
    output logic [DATA_W-1:0] o_read_byte,
    output logic [1:0]        o_region
);

    logic [DATA_W-1:0] pat_mem [2 * PATTERN_TABLE_BYTES];
    logic [DATA_W-1:0] nt_mem  [2 * NAMETABLE_BANK_BYTES];
    logic [DATA_W-1:0] pal_mem [PALETTE_BYTES];

    logic [DATA_W-1:0] r_pat_rd;
    logic [DATA_W-1:0] r_nt_rd;
    logic [DATA_W-1:0] r_pal_rd;
    logic              r_done;
    t_region           r_region;
    logic              r_is_write;

    logic              pat_we;
    logic              nt_we;
    logic              pal_we;

    assign pat_we = i_valid && i_access.is_write && (i_access.region == REGION_PATTERN);
    assign nt_we  = i_valid && i_access.is_write && (i_access.region == REGION_NAMETABLE);
    assign pal_we = i_valid && i_access.is_write && (i_access.region == REGION_PALETTE);

    // Pattern memory.
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            pat_mem[i_access.index[PAT_AW-1:0]] <= i_access.wdata;
        end
        r_pat_rd <= pat_mem[i_access.index[PAT_AW-1:0]];
    end

    // Nametable memory, both banks.
    always_ff @(posedge i_clk) begin
        if (nt_we) begin
            nt_mem[i_access.index[NT_AW-1:0]] <= i_access.wdata;
        end
        r_nt_rd <= nt_mem[i_access.index[NT_AW-1:0]];
    end

    // Palette memory.
    always_ff @(posedge i_clk) begin
        if (pal_we) begin
            pal_mem[i_access.index[PAL_AW-1:0]] <= i_access.wdata;
        end
        r_pal_rd <= pal_mem[i_access.index[PAL_AW-1:0]];
    end

    // Result strobe and the access kind that goes with the read data.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid) begin
            r_region   <= i_access.region;
            r_is_write <= i_access.is_write;
        end
    end

    // A write reports zero; a read returns the word of its store.
    always_comb begin
        o_read_byte = '0;
        if (!r_is_write) begin
            unique case (r_region)
                REGION_PATTERN:   o_read_byte = r_pat_rd;
                REGION_NAMETABLE: o_read_byte = r_nt_rd;
                REGION_PALETTE:   o_read_byte = r_pal_rd;
                default:          o_read_byte = '0;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_region = r_region;

endmodule

/* rtl/core/video_bus_address_decoder.sv */
// Video bus address decoder: a decode front, a two-entry queue, a memory back.
// o_done is registered: an accepted word is written into the queue, then the back registers the strobe.
// Throughput: one word per cycle, set by the single port of each store memory.
// The back drains one queue entry every cycle, so busy stays low in operation.
// Synchronous active-low reset clears the mode register, the queue and the strobe;
// the store contents are not cleared and read as undefined until written.
`timescale 1ns / 1ps

module video_bus_address_decoder import vbad_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_wdata,
    input  logic              start,
    output logic              busy,
    input  logic              i_req_type,
    input  logic [ADDR_W-1:0] i_bus_address,
    input  logic [DATA_W-1:0] i_write_byte,
    output logic              o_done,
    output logic [DATA_W-1:0] o_read_byte,
    output logic [1:0]        o_region
);

    t_access front_access;
    t_access queue_access;
    logic    queue_full;
    logic    queue_valid;
    logic    accept;

    assign busy   = queue_full;
    assign accept = start && !queue_full;

    // Decode of the incoming word.
    vbad_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_req_type    (i_req_type),
        .i_bus_address (i_bus_address),
        .i_write_byte  (i_write_byte),
        .o_access      (front_access)
    );

    // Decoupling queue; the back takes an entry whenever one is present.
    vbad_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (accept),
        .i_access (front_access),
        .i_pop    (queue_valid),
        .o_full   (queue_full),
        .o_valid  (queue_valid),
        .o_access (queue_access)
    );

    // Memory access and result.
    vbad_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (queue_valid),
        .i_access    (queue_access),
        .o_done      (o_done),
        .o_read_byte (o_read_byte),
        .o_region    (o_region)
    );

endmodule

/* rtl/core/vbad_checker.sv */
// Port-level checker for the video bus address decoder, bound to the top level.
// Depends on video_bus_address_decoder_assert.svh.
`timescale 1ns / 1ps

`include "video_bus_address_decoder_assert.svh"

module vbad_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       i_req_type,
    input logic       o_done,
    input logic [7:0] o_read_byte,
    input logic [1:0] o_region
);

    logic write_accepted;

    // A write word taken at this edge.
    assign write_accepted = start && !busy && i_req_type;

    // Every accepted word produces its strobe once it has passed the queue and the back's strobe register.
    `VBAD_ASSERT_NEXT(a_accept_gives_done, i_clk, i_rst_n, start && !busy, ##1 o_done)

    // No strobe without an accepted word that has passed the queue and the back's strobe register.
    `VBAD_ASSERT_NOW(a_done_has_cause, i_clk, i_rst_n, o_done, $past(start && !busy, 2))

    // A write reports a zero byte.
    `VBAD_ASSERT_NEXT(a_write_reads_zero, i_clk, i_rst_n, write_accepted, ##1 (o_read_byte == 8'd0))

    // A result never names the unused region code.
    `VBAD_ASSERT_NOW(a_region_legal, i_clk, i_rst_n, o_done, o_region != 2'd3)

endmodule

bind video_bus_address_decoder vbad_checker u_vbad_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_req_type  (i_req_type),
    .o_done      (o_done),
    .o_read_byte (o_read_byte),
    .o_region    (o_region)
);

/* sim/video_bus_address_decoder_tb.sv */
// Self-checking testbench for the video bus address decoder.
// Depends on vbad_pkg and video_bus_address_decoder; drives words from a queue
// and checks each result word against a behavioral model of the three stores.
`timescale 1ns / 1ps

module video_bus_address_decoder_tb;
    import vbad_pkg::*;

    // Flat layout of the model memory: pattern, then nametable, then palette.
    localparam int PAT_SPAN = 2 * PATTERN_TABLE_BYTES;
    localparam int NT_SPAN  = 2 * NAMETABLE_BANK_BYTES;
    localparam int MEM_SPAN = PAT_SPAN + NT_SPAN + PALETTE_BYTES;

    localparam int RANDOM_PHASES   = 8;
    localparam int WORDS_PER_PHASE = 125;
    localparam int REPORT_LIMIT    = 10;

    typedef struct {
        t_req_type         kind;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
    } t_bus_word;

    typedef struct {
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] rd;
        t_region           rgn;
    } t_video_result;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              i_cfg_we = 1'b0;
    logic              i_cfg_wdata = 1'b0;
    logic              start = 1'b0;
    logic              busy;
    logic              i_req_type = 1'b0;
    logic [ADDR_W-1:0] i_bus_address = '0;
    logic [DATA_W-1:0] i_write_byte = '0;
    logic              o_done;
    logic [DATA_W-1:0] o_read_byte;
    logic [1:0]        o_region;

    t_bus_word         pending_words[$];
    t_video_result     expected_results[$];
    logic [ADDR_W-1:0] written_addrs[$];
    logic [DATA_W-1:0] video_mem[MEM_SPAN];
    bit                gen_written[MEM_SPAN];
    logic              bank_high_mode = 1'b0;
    bit                idle_on = 1'b1;
    bit                word_taken = 1'b0;
    int                gap_left = 0;
    int                fail_count = 0;

    video_bus_address_decoder i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .start        (start),
        .busy         (busy),
        .i_req_type   (i_req_type),
        .i_bus_address(i_bus_address),
        .i_write_byte (i_write_byte),
        .o_done       (o_done),
        .o_read_byte  (o_read_byte),
        .o_region     (o_region)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // A hung handshake ends the run here.
    initial begin
        #5_000_000;
        $display("FAIL video_bus_address_decoder");
        $finish;
    end

    // Maps a bus address to its store and to an index in the flat model memory.
    function automatic void locate_cell(input logic [ADDR_W-1:0] a, input logic bank_hi,
                                        output t_region rgn, output int idx);
        logic [ADDR_W-1:0] na;
        if (a < NT_BASE) begin
            rgn = REGION_PATTERN;
            idx = int'(a[12]) * PATTERN_TABLE_BYTES + int'(a[11:0]) % PATTERN_TABLE_BYTES;
        end else if (a < PAL_BASE) begin
            na  = (a >= NT_MIRROR) ? a - MIRROR_STEP : a;
            rgn = REGION_NAMETABLE;
            idx = PAT_SPAN + int'(bank_hi ? na[11] : na[10]) * NAMETABLE_BANK_BYTES
                + int'(na[9:0]) % NAMETABLE_BANK_BYTES;
        end else begin
            rgn = REGION_PALETTE;
            idx = PAT_SPAN + NT_SPAN + int'(a[4:0]) % PALETTE_BYTES;
        end
    endfunction

    // Applies one accepted word to the model stores and returns the result it gives.
    function automatic t_video_result access_video_mem(t_bus_word w);
        t_video_result r;
        int            idx;
        locate_cell(w.addr, bank_high_mode, r.rgn, idx);
        r.addr = w.addr;
        if (w.kind == REQ_WRITE) begin
            video_mem[idx] = w.data;
            r.rd = '0;
        end else begin
            r.rd = video_mem[idx];
        end
        return r;
    endfunction

    // Idle cycles after a word: mostly none or short, now and then long.
    function automatic int idle_cycles();
        int roll;
        roll = $urandom_range(99);
        if (!idle_on || roll < 55) begin
            return 0;
        end else if (roll < 85) begin
            return $urandom_range(3, 1);
        end else if (roll < 97) begin
            return $urandom_range(12, 4);
        end
        return $urandom_range(60, 20);
    endfunction

    // Another address for the same cell: mirror, unused bank bit or palette fold.
    function automatic logic [ADDR_W-1:0] alias_address(logic [ADDR_W-1:0] base);
        logic [ADDR_W-1:0] a;
        a = base;
        if (a >= NT_BASE && a < PAL_BASE) begin
            if ($urandom_range(1)) begin
                if (bank_high_mode) begin
                    a[10] = ~a[10];
                end else begin
                    a[11] = ~a[11];
                end
            end
            if ($urandom_range(1)) begin
                if (a >= NT_MIRROR) begin
                    a = a - MIRROR_STEP;
                end else if (a + MIRROR_STEP < PAL_BASE) begin
                    a = a + MIRROR_STEP;
                end
            end
        end else if (a >= PAL_BASE) begin
            a[7:5] = 3'($urandom_range(7));
        end
        return a;
    endfunction

    // Queues one word; writes mark their cell so that later reads may target it.
    task automatic queue_access(t_req_type kind, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] data);
        t_bus_word w;
        t_region   rgn;
        int        idx;
        if (kind == REQ_WRITE) begin
            locate_cell(addr, bank_high_mode, rgn, idx);
            gen_written[idx] = 1'b1;
            written_addrs.push_back(addr);
        end
        w.kind = kind;
        w.addr = addr;
        w.data = data;
        pending_words.push_back(w);
    endtask

    // Random word: reads only hit cells already written, often through an alias.
    task automatic queue_random_access();
        logic [ADDR_W-1:0] base;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        t_region           rgn;
        int                idx;
        int                pick;
        data = DATA_W'($urandom);
        if ($urandom_range(99) < 45 && written_addrs.size() > 0) begin
            base = written_addrs[$urandom_range(written_addrs.size() - 1)];
            addr = alias_address(base);
            locate_cell(addr, bank_high_mode, rgn, idx);
            if (!gen_written[idx]) begin
                addr = base;
                locate_cell(addr, bank_high_mode, rgn, idx);
            end
            queue_access(gen_written[idx] ? REQ_READ : REQ_WRITE, addr, data);
        end else begin
            pick = $urandom_range(99);
            if (pick < 35) begin
                addr = ADDR_W'($urandom_range(16383));
            end else if (pick < 60) begin
                addr = ADDR_W'($urandom_range(14'h3EFF, 14'h2000));
            end else if (pick < 75) begin
                addr = ADDR_W'($urandom_range(14'h3FFF, 14'h3F00));
            end else if (pick < 90 && written_addrs.size() > 0) begin
                addr = written_addrs[$urandom_range(written_addrs.size() - 1)]
                     ^ ADDR_W'($urandom_range(15));
            end else begin
                case ($urandom_range(7))
                    0: addr = 14'h0000;
                    1: addr = 14'h0FFF;
                    2: addr = 14'h1FFF;
                    3: addr = 14'h2000;
                    4: addr = 14'h2FFF;
                    5: addr = 14'h3000;
                    6: addr = 14'h3EFF;
                    default: addr = 14'h3FFF;
                endcase
            end
            queue_access(REQ_WRITE, addr, data);
        end
    endtask

    // Waits until no word is queued, on the bus or awaiting its result.
    task automatic wait_idle();
        do begin
            @(posedge i_clk);
        end while (pending_words.size() != 0 || expected_results.size() != 0 || start);
    endtask

    // Writes the mode register while the block is idle.
    task automatic write_mode(logic value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        bank_high_mode = value;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
    endtask

    // Word driver: changes inputs at the falling edge, holds a word until taken.
    always @(negedge i_clk) begin : drive_words
        t_bus_word w;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (start && !word_taken) begin
            start <= 1'b1;
        end else if (gap_left > 0) begin
            gap_left = gap_left - 1;
            start <= 1'b0;
        end else if (pending_words.size() > 0) begin
            w = pending_words.pop_front();
            start         <= 1'b1;
            i_req_type    <= w.kind;
            i_bus_address <= w.addr;
            i_write_byte  <= w.data;
            gap_left = idle_cycles();
        end else begin
            start <= 1'b0;
        end
        word_taken = 1'b0;
    end

    // Result checker first, then acceptance of the word on the bus.
    always @(posedge i_clk) begin : check_and_accept
        t_video_result exp;
        t_bus_word     w;
        if (i_rst_n && o_done) begin
            if (expected_results.size() == 0) begin
                fail_count++;
                if (fail_count <= REPORT_LIMIT) begin
                    $display("unexpected result word: read_byte %h region %0d",
                             o_read_byte, o_region);
                end
            end else begin
                exp = expected_results.pop_front();
                if (o_read_byte !== exp.rd || o_region !== exp.rgn) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT) begin
                        $display({"mismatch at address %h: expected read_byte %h ",
                                  "region %0d, got %h %0d"},
                                 exp.addr, exp.rd, exp.rgn, o_read_byte, o_region);
                    end
                end
            end
        end
        if (i_rst_n && start && !busy) begin
            w.kind = t_req_type'(i_req_type);
            w.addr = i_bus_address;
            w.data = i_write_byte;
            expected_results.push_back(access_video_mem(w));
            word_taken = 1'b1;
        end
    end

    // Main sequence: reset, directed words, then random phases under changing modes.
    initial begin : run_sequence
        int p;
        int n;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Pattern store corners and both tables, with the reset mode.
        queue_access(REQ_WRITE, 14'h0000, 8'hFF);
        queue_access(REQ_WRITE, 14'h1FFF, 8'h00);
        queue_access(REQ_WRITE, 14'h1000, 8'hA5);
        queue_access(REQ_READ,  14'h0000, 8'h5A);
        queue_access(REQ_READ,  14'h1FFF, 8'hFF);
        queue_access(REQ_READ,  14'h1000, 8'h00);
        // Nametable banks by bit 10, and reads through the upper mirror.
        queue_access(REQ_WRITE, 14'h2000, 8'h11);
        queue_access(REQ_WRITE, 14'h2400, 8'h22);
        queue_access(REQ_WRITE, 14'h2EFF, 8'h66);
        queue_access(REQ_WRITE, 14'h2FFF, 8'h44);
        queue_access(REQ_READ,  14'h2800, 8'h00);
        queue_access(REQ_READ,  14'h3000, 8'hFF);
        queue_access(REQ_READ,  14'h3EFF, 8'h00);
        queue_access(REQ_READ,  14'h37FF, 8'hFF);
        // Palette folds every address in its page onto 32 entries.
        queue_access(REQ_WRITE, 14'h3F00, 8'h0F);
        queue_access(REQ_WRITE, 14'h3FFF, 8'hF0);
        queue_access(REQ_READ,  14'h3F20, 8'h00);
        queue_access(REQ_READ,  14'h3FE0, 8'hFF);
        queue_access(REQ_READ,  14'h3F1F, 8'h00);
        wait_idle();

        // Bank by bit 11: 0x2000 and 0x2400 now share a bank.
        write_mode(1'b1);
        queue_access(REQ_WRITE, 14'h2000, 8'h55);
        queue_access(REQ_READ,  14'h2400, 8'h00);
        queue_access(REQ_READ,  14'h3C00, 8'hFF);
        wait_idle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            write_mode(p == 0 ? 1'b0 : 1'($urandom_range(1)));
            idle_on = (p % 3 != 2);
            for (n = 0; n < WORDS_PER_PHASE; n++) begin
                queue_random_access();
            end
            wait_idle();
        end

        repeat (4) @(posedge i_clk);
        fail_count += expected_results.size();
        if (fail_count == 0) begin
            $display("PASS video_bus_address_decoder");
        end else begin
            $display("FAIL video_bus_address_decoder");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/vbad_pkg.sv
rtl/core/vbad_front.sv
rtl/core/vbad_queue.sv
rtl/core/vbad_back.sv
rtl/core/video_bus_address_decoder.sv
rtl/core/vbad_checker.sv
sim/video_bus_address_decoder_tb.sv
